// File: rtl/core/conv3_pkg.sv
// ----------------------------------------------------------------------------
// conv3_pkg: shared types and constants of the 3x3 stream filter
// Field widths, register indexes, reset values and the records that pass
// between the front part, the item queue and the back part.
// ----------------------------------------------------------------------------
package conv3_pkg;

	localparam int PIX_W         = 8;
	localparam int COUNT_W       = 11;
	localparam int TAP_W         = 5;
	localparam int KSIZE         = 3;
	localparam int NTAPS         = KSIZE * KSIZE;
	localparam int KERN_W        = NTAPS * TAP_W;
	localparam int LINE_W        = 2 * PIX_W;
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QAW           = $clog2(QUEUE_DEPTH);
	localparam int QCW           = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_IDX_W     = 2;

	localparam logic [COUNT_W-1:0] WIDTH_RESET  = COUNT_W'(640);
	localparam logic [COUNT_W-1:0] HEIGHT_RESET = COUNT_W'(480);
	localparam logic [PIX_W-1:0]   PAD_RESET    = PIX_W'(10);
	localparam logic [KERN_W-1:0]  KERN_RESET   = '0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_PAD_VALUE    = 2'd2,
		REG_KERNEL       = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [COUNT_W-1:0] frame_width;
		logic [COUNT_W-1:0] frame_height;
		logic [PIX_W-1:0]   pad_value;
		logic [KERN_W-1:0]  kernel_coeffs;
	} conv3_cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] bot;
		logic             first;
		logic             valid;
		logic             last;
	} conv3_entry_t;

endpackage

// File: rtl/core/conv3x3_stream_filter.sv
// ----------------------------------------------------------------------------
// conv3x3_stream_filter: streaming 3x3 convolution on 8-bit grey pixels
// Top level with configuration registers, front part, queue and back part.
// ----------------------------------------------------------------------------
// The block takes one item per clock and gives one result per item, as long
// as the output side takes results; items flow through the line memory read,
// a four-entry queue, the window register, the product stage and the output
// register. The host sends (frame_height+1) x (frame_width+1) items per
// frame, each row followed by one padding item and the frame by one padding
// row; the result of each item is for the pixel one row and one column back.
// The line memory holds two rows of MAX_WIDTH pixels in one word per column
// and needs no clearing after reset. Writing frame_width or frame_height
// restarts the frame.
module conv3x3_stream_filter #(
	parameter int MAX_WIDTH = conv3_pkg::MAX_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [conv3_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [conv3_pkg::KERN_W-1:0]    cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // [7:0] pixel
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [7:0]                      m_tdata,   // [7:0] filtered
	output logic [0:0]                      m_tuser,   // [0] valid_res
	output logic                            m_tlast
);
	import conv3_pkg::*;

	conv3_cfg_t     cfg_q;
	logic           restart;
	logic           push;
	conv3_entry_t   push_entry;
	logic           pop;
	conv3_entry_t   q_head;
	logic           q_empty;
	logic [QCW-1:0] q_count;
	logic           valid_res;

	assign restart = cfg_we && (cfg_reg_t'(cfg_index) == REG_FRAME_WIDTH ||
		cfg_reg_t'(cfg_index) == REG_FRAME_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width   <= WIDTH_RESET;
			cfg_q.frame_height  <= HEIGHT_RESET;
			cfg_q.pad_value     <= PAD_RESET;
			cfg_q.kernel_coeffs <= KERN_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH: begin
					cfg_q.frame_width <= cfg_wdata[COUNT_W-1:0];
				end
				REG_FRAME_HEIGHT: begin
					cfg_q.frame_height <= cfg_wdata[COUNT_W-1:0];
				end
				REG_PAD_VALUE: begin
					cfg_q.pad_value <= cfg_wdata[PIX_W-1:0];
				end
				REG_KERNEL: begin
					cfg_q.kernel_coeffs <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	conv3_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.restart   (restart),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.pixel     (s_tdata),
		.q_count   (q_count),
		.push      (push),
		.push_entry(push_entry)
	);

	conv3_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head      (q_head),
		.empty     (q_empty),
		.count     (q_count)
	);

	conv3_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_head   (q_head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.filtered (m_tdata),
		.valid_res(valid_res),
		.last     (m_tlast)
	);

	assign m_tuser = valid_res;

endmodule

// File: rtl/core/conv3_ram.sv
// ----------------------------------------------------------------------------
// conv3_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module conv3_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/core/conv3_front.sv
// ----------------------------------------------------------------------------
// conv3_front: item intake and line buffering
// Tracks the raster position, classifies each item, reads and updates the
// two-row line memory and pushes one window column per item into the queue.
// ----------------------------------------------------------------------------
module conv3_front #(
	parameter int MAX_WIDTH = conv3_pkg::MAX_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  conv3_pkg::conv3_cfg_t       cfg,
	input  logic                        restart,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [conv3_pkg::PIX_W-1:0] pixel,
	input  logic [conv3_pkg::QCW-1:0]   q_count,
	output logic                        push,
	output conv3_pkg::conv3_entry_t     push_entry
);
	import conv3_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam logic [COUNT_W+1:0] MAXW = (COUNT_W + 2)'(MAX_WIDTH);

	logic [COUNT_W-1:0] w_eff;
	logic [COUNT_W-1:0] h;
	logic [COUNT_W-1:0] col_q;
	logic [COUNT_W-1:0] row_q;
	logic               accept;
	logic [QCW:0]       used;
	logic               col_in;
	logic               real_px;

	logic               s1_valid_q;
	logic [AW-1:0]      addr_s1;
	logic               col_in_s1;
	logic               need_mid_s1;
	logic               need_top_s1;
	logic [PIX_W-1:0]   bot_s1;
	logic               first_s1;
	logic               valid_s1;
	logic               last_s1;
	logic [LINE_W-1:0]  rd_data;

	assign w_eff   = ({2'b00, cfg.frame_width} > MAXW) ? COUNT_W'(MAXW) : cfg.frame_width;
	assign h       = cfg.frame_height;
	assign used    = (QCW + 1)'(q_count) + (QCW + 1)'(s1_valid_q);
	assign s_tready = used < (QCW + 1)'(QUEUE_DEPTH);
	assign accept  = s_tvalid && s_tready;
	assign col_in  = col_q < w_eff;
	assign real_px = col_in && (row_q < h);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept;
			if (restart) begin
				col_q <= '0;
				row_q <= '0;
			end else if (accept) begin
				if (col_q >= w_eff) begin
					col_q <= '0;
					row_q <= (row_q >= h) ? '0 : row_q + COUNT_W'(1);
				end else begin
					col_q <= col_q + COUNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1     <= AW'(col_q);
			col_in_s1   <= col_in;
			need_mid_s1 <= col_in && (row_q >= COUNT_W'(1));
			need_top_s1 <= col_in && (row_q >= COUNT_W'(2));
			bot_s1      <= real_px ? pixel : cfg.pad_value;
			first_s1    <= col_q == '0;
			valid_s1    <= (row_q >= COUNT_W'(1)) && (col_q >= COUNT_W'(1)) &&
				(row_q <= h) && (col_q <= w_eff);
			last_s1     <= (row_q >= COUNT_W'(1)) && (col_q >= COUNT_W'(1)) &&
				(row_q == h) && (col_q == w_eff);
		end
	end

	conv3_ram #(
		.WIDTH(LINE_W),
		.DEPTH(MAX_WIDTH)
	) u_line (
		.clk  (clk),
		.we   (s1_valid_q && col_in_s1),
		.waddr(addr_s1),
		.wdata({rd_data[PIX_W-1:0], bot_s1}),
		.re   (accept),
		.raddr(AW'(col_q)),
		.rdata(rd_data)
	);

	assign push             = s1_valid_q;
	assign push_entry.top   = need_top_s1 ? rd_data[LINE_W-1:PIX_W] : cfg.pad_value;
	assign push_entry.mid   = need_mid_s1 ? rd_data[PIX_W-1:0] : cfg.pad_value;
	assign push_entry.bot   = bot_s1;
	assign push_entry.first = first_s1;
	assign push_entry.valid = valid_s1;
	assign push_entry.last  = last_s1;

	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= w_eff)
		else $error("column counter ran past the row end");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= h)
		else $error("row counter ran past the padding row");

endmodule

// File: rtl/core/conv3_queue.sv
// ----------------------------------------------------------------------------
// conv3_queue: short item queue between front and back
// Holds window columns so that intake and output can stall independently.
// ----------------------------------------------------------------------------
module conv3_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  conv3_pkg::conv3_entry_t   push_entry,
	input  logic                      pop,
	output conv3_pkg::conv3_entry_t   head,
	output logic                      empty,
	output logic [conv3_pkg::QCW-1:0] count
);
	import conv3_pkg::*;

	conv3_entry_t   mem_q [QUEUE_DEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;

	assign head  = mem_q[rd_ptr_q];
	assign empty = count_q == '0;
	assign count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			count_q <= count_q + QCW'(push) - QCW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> count_q < QCW'(QUEUE_DEPTH))
		else $error("item pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("item popped from an empty queue");

endmodule

// File: rtl/core/conv3_back.sv
// ----------------------------------------------------------------------------
// conv3_back: window shift and nine-tap sum
// Shifts each queued column into the 3x3 window, forms the tap products in
// one stage and their byte sum in the next, into the output register.
// ----------------------------------------------------------------------------
module conv3_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  conv3_pkg::conv3_cfg_t       cfg,
	input  logic                        q_empty,
	input  conv3_pkg::conv3_entry_t     q_head,
	output logic                        pop,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [conv3_pkg::PIX_W-1:0] filtered,
	output logic                        valid_res,
	output logic                        last
);
	import conv3_pkg::*;

	logic             en;
	logic [PIX_W-1:0] win_q [KSIZE][KSIZE];
	logic             v_s1;
	logic             valid_s1;
	logic             last_s1;
	logic [PIX_W-1:0] prod_c [NTAPS];
	logic [PIX_W-1:0] prod_s2 [NTAPS];
	logic             v_s2;
	logic             valid_s2;
	logic             last_s2;
	logic [PIX_W-1:0] sum_c;
	logic             out_valid_q;
	logic [PIX_W-1:0] filtered_q;
	logic             valid_q;
	logic             last_q;

	assign en  = !out_valid_q || m_tready;
	assign pop = en && !q_empty;

	always_ff @(posedge clk) begin
		if (pop) begin
			for (int i = 0; i < KSIZE; i++) begin
				for (int j = 0; j < KSIZE - 1; j++) begin
					win_q[i][j] <= q_head.first ? cfg.pad_value : win_q[i][j+1];
				end
			end
			win_q[0][KSIZE-1] <= q_head.top;
			win_q[1][KSIZE-1] <= q_head.mid;
			win_q[2][KSIZE-1] <= q_head.bot;
		end
	end

	always_comb begin
		logic [TAP_W-1:0] tap;
		logic [PIX_W-1:0] tap8;
		for (int t = 0; t < NTAPS; t++) begin
			tap       = cfg.kernel_coeffs[t*TAP_W +: TAP_W];
			tap8      = {{(PIX_W - TAP_W){tap[TAP_W-1]}}, tap};
			prod_c[t] = PIX_W'((2 * PIX_W)'(win_q[t / KSIZE][t % KSIZE]) * (2 * PIX_W)'(tap8));
		end
	end

	always_comb begin
		sum_c = prod_s2[0];
		for (int t = 1; t < NTAPS; t++) begin
			sum_c = sum_c + prod_s2[t];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= pop;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (pop) begin
				valid_s1 <= q_head.valid;
				last_s1  <= q_head.last;
			end
			prod_s2    <= prod_c;
			valid_s2   <= valid_s1;
			last_s2    <= last_s1;
			filtered_q <= valid_s2 ? sum_c : '0;
			valid_q    <= valid_s2;
			last_q     <= valid_s2 && last_s2;
		end
	end

	assign m_tvalid  = out_valid_q;
	assign filtered  = filtered_q;
	assign valid_res = valid_q;
	assign last      = last_q;

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !valid_q |-> filtered_q == '0 && !last_q)
		else $error("result without a centre pixel carries data");

endmodule
